[design/tdkpc_pkg.sv]
// Package for the two-key press duration classifier.
// Holds the configuration, lane status and result types, and the event codes.
// No dependencies; the lane, merge and top-level design files import it.
package tdkpc_pkg;

  localparam int REG_W = 10;

  localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] CFG_LONG      = 2'd1;
  localparam logic [1:0] CFG_VERY_LONG = 2'd2;

  localparam logic [REG_W-1:0] DEBOUNCE_RESET  = 10'd2;
  localparam logic [REG_W-1:0] LONG_RESET      = 10'd100;
  localparam logic [REG_W-1:0] VERY_LONG_RESET = 10'd1000;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_SHORT     = 2'd1;
  localparam logic [1:0] EV_LONG      = 2'd2;
  localparam logic [1:0] EV_VERY_LONG = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0] debounce_count;
    logic [REG_W-1:0] long_count;
    logic [REG_W-1:0] very_long_count;
  } cfg_regs_t;

  typedef struct packed {
    logic released;
    logic advance;
    logic first_tick;
    logic at_debounce;
    logic at_long;
    logic at_very_long;
    logic release_short;
  } lane_stat_t;

  typedef struct packed {
    logic       shutdown_request;
    logic [1:0] key1_event;
    logic [1:0] key0_event;
  } result_t;

endpackage

[design/tdkpc_lane.sv]
// One key lane: the saturating hold counter and its threshold compares.
// Depends on tdkpc_pkg; two instances feed tdkpc_merge.
module tdkpc_lane
  import tdkpc_pkg::*;
#(
  parameter int COUNT_WIDTH = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic       pressed,
  input  cfg_regs_t  cfg,
  output lane_stat_t stat
);

  localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [COUNT_WIDTH-1:0] hold_count_r;
  logic [COUNT_WIDTH-1:0] hold_count_nxt;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       inc_ext;
  logic [CMP_W-1:0]       deb_ext;
  logic [CMP_W-1:0]       long_ext;
  logic [CMP_W-1:0]       vlong_ext;
  logic [CMP_W-1:0]       sat_ext;

  assign cnt_ext   = CMP_W'(hold_count_r);
  assign inc_ext   = cnt_ext + CMP_W'(1);
  assign deb_ext   = CMP_W'(cfg.debounce_count);
  assign long_ext  = CMP_W'(cfg.long_count);
  assign vlong_ext = CMP_W'(cfg.very_long_count);
  assign sat_ext   = (vlong_ext < COUNT_MAX) ? vlong_ext : COUNT_MAX;

  always_comb begin
    stat.released      = !pressed;
    stat.advance       = pressed && (cnt_ext < sat_ext);
    stat.first_tick    = (inc_ext == CMP_W'(1));
    stat.at_debounce   = (inc_ext == deb_ext);
    stat.at_long       = (inc_ext == long_ext);
    stat.at_very_long  = (inc_ext == vlong_ext);
    stat.release_short = !pressed && (cnt_ext >= deb_ext) && (cnt_ext < long_ext);
  end

  always_comb begin
    if (!pressed) begin
      hold_count_nxt = '0;
    end else if (stat.advance) begin
      hold_count_nxt = inc_ext[COUNT_WIDTH-1:0];
    end else begin
      hold_count_nxt = sat_ext[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_count_r <= '0;
    end else if (step_en) begin
      hold_count_r <= hold_count_nxt;
    end
  end

endmodule

[design/tdkpc_merge.sv]
// Merging stage: applies the per-key event rules to the two lane reports.
// Holds the press flags of key 0. Depends on tdkpc_pkg.
module tdkpc_merge
  import tdkpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic       idle,
  input  lane_stat_t st0,
  input  lane_stat_t st1,
  output result_t    res
);

  logic short_sent_r, short_sent_nxt;
  logic shut_sent_r, shut_sent_nxt;
  logic began_idle_r, began_idle_nxt;

  always_comb begin
    res            = '0;
    short_sent_nxt = short_sent_r;
    shut_sent_nxt  = shut_sent_r;
    began_idle_nxt = began_idle_r;

    if (st0.released) begin
      if (st0.release_short && !short_sent_r) begin
        res.key0_event = EV_SHORT;
      end
      short_sent_nxt = 1'b0;
      shut_sent_nxt  = 1'b0;
      began_idle_nxt = 1'b0;
    end else if (st0.advance) begin
      if (st0.first_tick) begin
        began_idle_nxt = idle;
      end
      if (idle && st0.at_debounce && !short_sent_r) begin
        res.key0_event = EV_SHORT;
        short_sent_nxt = 1'b1;
      end
      if (st0.at_long && !began_idle_nxt) begin
        res.key0_event = EV_LONG;
        if (!shut_sent_r) begin
          res.shutdown_request = 1'b1;
          shut_sent_nxt        = 1'b1;
        end
      end
    end

    if (st1.released) begin
      if (st1.release_short) begin
        res.key1_event = EV_SHORT;
      end
    end else if (st1.advance) begin
      if (st1.at_long) begin
        res.key1_event = EV_LONG;
      end else if (st1.at_very_long) begin
        res.key1_event = EV_VERY_LONG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_sent_r <= 1'b0;
      shut_sent_r  <= 1'b0;
      began_idle_r <= 1'b0;
    end else if (step_en) begin
      short_sent_r <= short_sent_nxt;
      shut_sent_r  <= shut_sent_nxt;
      began_idle_r <= began_idle_nxt;
    end
  end

endmodule

[design/two_key_press_duration_classifier.sv]
// Two-key press duration classifier, top level.
// Instantiates two tdkpc_lane blocks and tdkpc_merge; depends on tdkpc_pkg.
//
// Every input transaction is one scan tick and produces exactly one result
// transaction carrying the events of both keys and the shutdown pulse. A tick
// is taken every clock cycle while the skid register is empty: the two key
// lanes and the merging stage are combinational compare logic, and the result
// sits in an output register backed by a one-entry skid register, so input
// stays ready while one result waits. Configuration writes take effect on the
// next cycle and should be made while no tick is in flight.
module two_key_press_duration_classifier
  import tdkpc_pkg::*;
#(
  parameter int COUNT_WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [0] key0_level, [1] key1_level, [2] system_idle, [7:3] zero
  input  logic [7:0]       in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [1:0] key0_event, [3:2] key1_event, [4] shutdown_request, [7:5] zero
  output logic [7:0]       out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_wdata
);

  cfg_regs_t  cfg_r;
  lane_stat_t st0, st1;
  result_t    res;
  result_t    out_data_r, skid_data_r;
  logic       out_valid_r, skid_valid_r;
  logic       step_en;

  assign in_tready = !skid_valid_r;
  assign step_en   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_count  <= DEBOUNCE_RESET;
      cfg_r.long_count      <= LONG_RESET;
      cfg_r.very_long_count <= VERY_LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  cfg_r.debounce_count  <= cfg_wdata;
        CFG_LONG:      cfg_r.long_count      <= cfg_wdata;
        CFG_VERY_LONG: cfg_r.very_long_count <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tdkpc_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .pressed (!in_tdata[0]),
    .cfg     (cfg_r),
    .stat    (st0)
  );

  tdkpc_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .pressed (!in_tdata[1]),
    .cfg     (cfg_r),
    .stat    (st1)
  );

  tdkpc_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .idle    (in_tdata[2]),
    .st0     (st0),
    .st1     (st1),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || step_en;
      skid_valid_r <= 1'b0;
    end else if (step_en) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (step_en) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

endmodule

[design/tdkpc_checker.sv]
// Port-level checker for the two-key press duration classifier.
// Depends on the top level's ports only; bound to it below.
module tdkpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  a_key0_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3 && out_tdata[7:5] == 3'd0)
    else $error("illegal key 0 event or padding bits set");

  a_shut_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[1:0] == 2'd2)
    else $error("shutdown request without key 0 long press");

  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled while no result is pending");

endmodule

bind two_key_press_duration_classifier tdkpc_checker u_tdkpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[dv/two_key_press_duration_classifier_tb.sv]
// Self-checking testbench for two_key_press_duration_classifier.
// Drives scan ticks on the input stream, predicts the key events and checks each
// result transaction in order; depends only on tdkpc_pkg and the block itself.
module two_key_press_duration_classifier_tb;
  import tdkpc_pkg::*;

  localparam int COUNT_WIDTH = 10;
  localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH) - 1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 80;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [REG_W-1:0] cfg_wdata;

  cfg_regs_t   thr;
  int unsigned held[2];
  bit          short_done[2];
  bit          shutdown_done;
  bit          began_idle;

  result_t pending_events[$];
  int      fail_count;
  int      quiet_cycles;
  bit      sender_gaps;
  bit      sink_stalls;
  bit      hold_req;
  int      hold_left;
  int      stall_left;

  two_key_press_duration_classifier #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic result_t classify_tick(input bit lvl0, input bit lvl1, input bit idle);
    result_t     res;
    bit          pressed;
    int unsigned sat;
    int unsigned c;
    int unsigned n;
    logic [1:0]  ev[2];
    int          k;
    ev[0] = EV_NONE;
    ev[1] = EV_NONE;
    res.shutdown_request = 1'b0;
    sat = (thr.very_long_count < COUNT_MAX) ? 32'(thr.very_long_count) : COUNT_MAX;
    for (k = 0; k < 2; k++) begin
      pressed = (k == 0) ? !lvl0 : !lvl1;
      c = held[k];
      if (pressed) begin
        if (c < sat) begin
          n = c + 1;
          held[k] = n;
          if (k == 0 && n == 1) began_idle = idle;
          if (k == 0 && idle && n == thr.debounce_count && !short_done[0]) begin
            ev[0] = EV_SHORT;
            short_done[0] = 1'b1;
          end
          if (n == thr.long_count) begin
            if (!(k == 0 && began_idle)) ev[k] = EV_LONG;
            if (k == 0 && !shutdown_done && !began_idle) begin
              res.shutdown_request = 1'b1;
              shutdown_done = 1'b1;
            end
          end else if (k == 1 && n == thr.very_long_count) begin
            ev[1] = EV_VERY_LONG;
          end
        end else begin
          held[k] = sat;
        end
      end else begin
        if (c >= thr.debounce_count && c < thr.long_count && !short_done[k]) ev[k] = EV_SHORT;
        held[k] = 0;
        short_done[k] = 1'b0;
        if (k == 0) begin
          shutdown_done = 1'b0;
          began_idle = 1'b0;
        end
      end
    end
    res.key0_event = ev[0];
    res.key1_event = ev[1];
    return res;
  endfunction

  task automatic send_tick(input bit lvl0, input bit lvl1, input bit idle);
    if (sender_gaps && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, idle, lvl1, lvl0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_events.push_back(classify_tick(lvl0, lvl1, idle));
  endtask

  task automatic press_for(input bit p0, input bit p1, input bit idle, input int n);
    repeat (n) send_tick(!p0, !p1, idle);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_thresholds(input int unsigned d, input int unsigned l,
                                 input int unsigned v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= d[REG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_LONG;
    cfg_wdata <= l[REG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_VERY_LONG;
    cfg_wdata <= v[REG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= REG_W'($urandom_range(0, COUNT_MAX));
    @(posedge clk);
    cfg_we <= 1'b0;
    thr.debounce_count  = d[REG_W-1:0];
    thr.long_count      = l[REG_W-1:0];
    thr.very_long_count = v[REG_W-1:0];
    @(posedge clk);
  endtask

  function automatic int unsigned pick_hold();
    int unsigned d;
    int unsigned l;
    int unsigned v;
    d = 32'(thr.debounce_count);
    l = 32'(thr.long_count);
    v = 32'(thr.very_long_count);
    case ($urandom_range(0, 4))
      0: return $urandom_range(1, d + 2);
      1: return $urandom_range((l > 1) ? l - 1 : 1, l + 1);
      2: return $urandom_range((v > 1) ? v - 1 : 1, v + 2);
      default: return $urandom_range(1, v + 3);
    endcase
  endfunction

  task automatic random_presses(input int n);
    bit lvl[2];
    int left[2];
    bit idle;
    int i;
    int k;
    lvl[0] = 1'b1;
    lvl[1] = 1'b1;
    left[0] = 0;
    left[1] = int'($urandom_range(0, 3));
    idle = 1'($urandom_range(0, 1));
    for (i = 0; i < n; i++) begin
      for (k = 0; k < 2; k++) begin
        if (left[k] == 0) begin
          lvl[k] = !lvl[k];
          left[k] = lvl[k] ? int'($urandom_range(1, 4)) : int'(pick_hold());
        end
        left[k]--;
      end
      if ($urandom_range(0, 15) == 0) idle = !idle;
      if ($urandom_range(0, 19) == 0)
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else
        send_tick(lvl[0], lvl[1], idle);
    end
  endtask

  task automatic test_reset_values();
    press_for(1'b1, 1'b1, 1'b0, 3);
    press_for(1'b0, 1'b0, 1'b0, 1);
    press_for(1'b1, 1'b0, 1'b1, 2);
    press_for(1'b1, 1'b1, 1'b1, 1);
    press_for(1'b0, 1'b0, 1'b1, 1);
  endtask

  task automatic test_long_and_very_long();
    load_thresholds(2, 4, 6);
    press_for(1'b1, 1'b1, 1'b0, 7);
    press_for(1'b0, 1'b0, 1'b0, 1);
    press_for(1'b1, 1'b0, 1'b1, 5);
    press_for(1'b0, 1'b0, 1'b1, 1);
  endtask

  task automatic test_threshold_extremes();
    load_thresholds(1, 2, 3);
    press_for(1'b1, 1'b1, 1'b0, 5);
    press_for(1'b0, 1'b0, 1'b1, 2);
    press_for(1'b1, 1'b1, 1'b1, 4);
    press_for(1'b0, 1'b0, 1'b0, 1);
    load_thresholds(COUNT_MAX, COUNT_MAX, COUNT_MAX);
    press_for(1'b1, 1'b1, 1'b0, 6);
    press_for(1'b0, 1'b0, 1'b0, 2);
    load_thresholds(0, 0, 0);
    random_presses(20);
    load_thresholds(0, 5, 8);
    random_presses(30);
    load_thresholds(5, 3, 9);
    random_presses(30);
  endtask

  task automatic test_random_sweeps();
    int unsigned d;
    int unsigned l;
    int unsigned v;
    int p;
    for (p = 0; p < 5; p++) begin
      d = $urandom_range(1, 4);
      l = d + $urandom_range(1, 8);
      v = l + $urandom_range(1, 8);
      if ($urandom_range(0, 4) == 0) v = $urandom_range(3, l);
      load_thresholds(d, l, v);
      random_presses(90);
    end
  endtask

  task automatic test_output_backpressure();
    load_thresholds(2, 5, 9);
    sender_gaps = 1'b0;
    hold_req = 1'b1;
    random_presses(40);
    sender_gaps = 1'b1;
  endtask

  task automatic test_final_calm();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    load_thresholds(3, 7, 12);
    random_presses(60);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[4:0]);
      if (pending_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result transaction: data %h", out_tdata);
      end else begin
        want = pending_events.pop_front();
        if (got.key0_event !== want.key0_event || got.key1_event !== want.key1_event ||
            got.shutdown_request !== want.shutdown_request || out_tdata[7:5] !== 3'b0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: key0 %0d/%0d key1 %0d/%0d shutdown %0d/%0d pad %b",
                     want.key0_event, got.key0_event, want.key1_event, got.key1_event,
                     want.shutdown_request, got.shutdown_request, out_tdata[7:5]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_wdata = '0;
    fail_count = 0;
    quiet_cycles = 0;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    thr.debounce_count = DEBOUNCE_RESET;
    thr.long_count = LONG_RESET;
    thr.very_long_count = VERY_LONG_RESET;
    held[0] = 0;
    held[1] = 0;
    short_done[0] = 1'b0;
    short_done[1] = 1'b0;
    shutdown_done = 1'b0;
    began_idle = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_long_and_very_long();
    test_threshold_extremes();
    test_random_sweeps();
    test_output_backpressure();
    test_final_calm();
    drain_results();
    if (pending_events.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
